// ===== rtl/fcds_pkg.sv =====
// fcds_pkg: codes, constants and shared types for the fan curve duty selector.
// No dependencies; imported by fcds_div and fan_curve_duty_select_core.
`default_nettype none

package fcds_pkg;

	// fan_mode codes
	localparam logic [1:0] MODE_MANUAL   = 2'd0;
	localparam logic [1:0] MODE_CURVE    = 2'd1;
	localparam logic [1:0] MODE_FIRMWARE = 2'd2;

	// curve_source codes
	localparam logic [1:0] SRC_CPU  = 2'd0;
	localparam logic [1:0] SRC_GPU  = 2'd1;
	localparam logic [1:0] SRC_MAX  = 2'd2;
	localparam logic [1:0] SRC_NONE = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_FAN_MODE     = 3'd0;
	localparam logic [2:0] REG_MANUAL_DUTY  = 3'd1;
	localparam logic [2:0] REG_CURVE_SOURCE = 3'd2;
	localparam logic [2:0] REG_POINT_COUNT  = 3'd3;
	localparam logic [2:0] REG_CURVE_TEMPS  = 3'd4;
	localparam logic [2:0] REG_CURVE_DUTIES = 3'd5;

	localparam logic [7:0] DUTY_FULL = 8'd255;

	// per-item data riding alongside the pipeline and the divider
	typedef struct packed {
		logic       direct;    // result does not come from the curve
		logic       drive;
		logic [7:0] fix_duty;  // duty when direct
		logic       found;     // a point at or above t exists
		logic       plain;     // use the upper point duty as is
		logic       neg;       // duty falls between the points
		logic [7:0] dk;
		logic [7:0] dp;
	} side_t;

endpackage

`default_nettype wire

// ===== rtl/fcds_div.sv =====
// fcds_div: four-stage pipelined restoring divider, 16-bit by 8-bit, 8-bit quotient.
// Two quotient bits per stage; carries a side_t beat along. Depends on fcds_pkg.
`default_nettype none

module fcds_div import fcds_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [15:0] num,
	input  wire logic [7:0]  den,
	input  wire side_t       in_side,
	output logic             out_valid,
	output logic [7:0]       quo,
	output side_t            out_side
);

	// Working word: remainder in the upper byte, dividend bits then quotient
	// bits in the lower byte. Caller guarantees num[15:8] < den.
	function automatic logic [15:0] step2(input logic [15:0] w, input logic [7:0] d);
		logic [15:0] x;
		logic [8:0]  r;
		logic [8:0]  diff;
		int          i;
		x = w;
		for (i = 0; i < 2; i++) begin
			r    = x[15:7];
			diff = r - {1'b0, d};
			if (r >= {1'b0, d}) begin
				x = {diff[7:0], x[6:0], 1'b1};
			end else begin
				x = {r[7:0], x[6:0], 1'b0};
			end
		end
		return x;
	endfunction

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [15:0] w_s1, w_s2, w_s3, w_s4;
	logic [7:0]  den_s1, den_s2, den_s3;
	side_t       side_s1, side_s2, side_s3, side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		w_s1    <= step2(num, den);
		den_s1  <= den;
		side_s1 <= in_side;
		w_s2    <= step2(w_s1, den_s1);
		den_s2  <= den_s1;
		side_s2 <= side_s1;
		w_s3    <= step2(w_s2, den_s2);
		den_s3  <= den_s2;
		side_s3 <= side_s2;
		w_s4    <= step2(w_s3, den_s3);
		side_s4 <= side_s3;
	end

	assign out_valid = valid_s4;
	assign quo       = w_s4[7:0];
	assign out_side  = side_s4;

endmodule

`default_nettype wire

// ===== rtl/fan_curve_duty_select_core.sv =====
// fan_curve_duty_select_core: fan duty selector with a piecewise linear curve.
// Depends on fcds_pkg and fcds_div.
//
// channel   signals                                   direction
// command   start, busy, cpu_temp, gpu_temp           in  (accepted on start && !busy)
// result    done, duty, drive_mode, emergency         out (one-cycle strobe)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in  (write on valid && ready)
//
// Nine-stage pipeline: select, point compare, segment fetch, multiply, four
// divider stages (two quotient bits each), output register. A new sample may
// enter every cycle; done rises with its result in the output register.
// busy and cfg_ready are constant, the result side cannot stall, so nothing
// in the pipe ever holds. Reset restores the register defaults and empties
// the pipe.
`default_nettype none

module fan_curve_duty_select_core import fcds_pkg::*; #(
	parameter int POINTS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  cpu_temp,
	input  wire logic [7:0]  gpu_temp,
	output logic             done,
	output logic [7:0]       duty,
	output logic             drive_mode,
	output logic             emergency,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	// configuration registers
	logic [1:0]  fan_mode_q;
	logic [7:0]  manual_duty_q;
	logic [1:0]  curve_source_q;
	logic [3:0]  point_count_q;
	logic [63:0] curve_temps_q;
	logic [63:0] curve_duties_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_mode_q     <= MODE_FIRMWARE;
			manual_duty_q  <= 8'd255;
			curve_source_q <= SRC_MAX;
			point_count_q  <= 4'd0;
			curve_temps_q  <= 64'd0;
			curve_duties_q <= 64'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FAN_MODE:     fan_mode_q     <= cfg_data[1:0];
				REG_MANUAL_DUTY:  manual_duty_q  <= cfg_data[7:0];
				REG_CURVE_SOURCE: curve_source_q <= cfg_data[1:0];
				REG_POINT_COUNT:  point_count_q  <= cfg_data[3:0];
				REG_CURVE_TEMPS:  curve_temps_q  <= cfg_data;
				REG_CURVE_DUTIES: curve_duties_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [7:0] temp_b [POINTS];
	logic [7:0] duty_b [POINTS];

	always_comb begin
		for (int i = 0; i < POINTS; i++) begin
			temp_b[i] = curve_temps_q[8*i +: 8];
			duty_b[i] = curve_duties_q[8*i +: 8];
		end
	end

	// ---- stage 1: mode decode and source select
	logic       valid_s1;
	logic [7:0] t_s1;
	side_t      side_s1;
	logic [7:0] t_sel;
	side_t      side_in;

	always_comb begin
		case (curve_source_q)
			SRC_CPU: t_sel = cpu_temp;
			SRC_GPU: t_sel = gpu_temp;
			default: t_sel = (cpu_temp > gpu_temp) ? cpu_temp : gpu_temp;
		endcase
		side_in = '0;
		case (fan_mode_q)
			MODE_MANUAL: begin
				side_in.direct   = 1'b1;
				side_in.drive    = 1'b1;
				side_in.fix_duty = manual_duty_q;
			end
			MODE_CURVE: begin
				side_in.direct = (curve_source_q == SRC_NONE);
				side_in.drive  = 1'b1;
			end
			default: begin
				side_in.direct = 1'b1;
			end
		endcase
	end

	// ---- stage 2: compare against every point in use
	logic               valid_s2;
	logic [7:0]         t_s2;
	side_t              side_s2;
	logic [POINTS-1:0]  hit;
	logic [POINTS-1:0]  hit_s2;
	logic [3:0]         n_used;

	always_comb begin
		n_used = (point_count_q > 4'(POINTS)) ? 4'(POINTS) : point_count_q;
		for (int k = 0; k < POINTS; k++) begin
			hit[k] = (4'(k) < n_used) && (t_s1 <= temp_b[k]);
		end
	end

	// ---- stage 3: first hit, segment fetch, differences
	logic              valid_s3;
	side_t             side_s3;
	logic [7:0]        mag_s3;
	logic [7:0]        dt_s3;
	logic [7:0]        span_s3;
	logic [POINTS-1:0] first;
	logic [7:0]        tk, dk, tp, dp;
	logic [8:0]        dd, span;
	logic [7:0]        mag;
	side_t             side_fetch;

	always_comb begin
		first = '0;
		for (int k = 0; k < POINTS; k++) begin
			first[k] = hit_s2[k] && ((hit_s2 & ((POINTS'(1) << k) - POINTS'(1))) == '0);
		end
		tk = '0;
		dk = '0;
		tp = '0;
		dp = '0;
		for (int k = 0; k < POINTS; k++) begin
			tk = tk | (first[k] ? temp_b[k] : 8'd0);
			dk = dk | (first[k] ? duty_b[k] : 8'd0);
		end
		for (int k = 1; k < POINTS; k++) begin
			tp = tp | (first[k] ? temp_b[k-1] : 8'd0);
			dp = dp | (first[k] ? duty_b[k-1] : 8'd0);
		end
		dd   = {1'b0, dk} - {1'b0, dp};
		span = {1'b0, tk} - {1'b0, tp};
		mag  = dd[8] ? 8'(-dd) : dd[7:0];
		side_fetch       = side_s2;
		side_fetch.found = |hit_s2;
		// first point, or flat/descending segment: upper duty as is
		side_fetch.plain = first[0] || span[8] || (span == 9'd0);
		side_fetch.neg   = dd[8];
		side_fetch.dk    = dk;
		side_fetch.dp    = dp;
	end

	// ---- stage 4: multiply
	logic        valid_s4;
	side_t       side_s4;
	logic [15:0] prod_s4;
	logic [7:0]  den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		t_s1    <= t_sel;
		side_s1 <= side_in;
		t_s2    <= t_s1;
		side_s2 <= side_s1;
		hit_s2  <= hit;
		side_s3 <= side_fetch;
		mag_s3  <= mag;
		dt_s3   <= t_s2 - tp;
		span_s3 <= span[7:0];
		side_s4 <= side_s3;
		prod_s4 <= {8'd0, mag_s3} * {8'd0, dt_s3};
		den_s4  <= span_s3;
	end

	// ---- stages 5..8: divider
	logic       div_valid;
	logic [7:0] quo;
	side_t      div_side;

	fcds_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.num       (prod_s4),
		.den       (den_s4),
		.in_side   (side_s4),
		.out_valid (div_valid),
		.quo       (quo),
		.out_side  (div_side)
	);

	// ---- stage 9: result
	logic [7:0] duty_d;
	logic       emerg_d;

	always_comb begin
		emerg_d = 1'b0;
		if (div_side.direct) begin
			duty_d = div_side.fix_duty;
		end else if (!div_side.found) begin
			duty_d  = DUTY_FULL;
			emerg_d = 1'b1;
		end else if (div_side.plain) begin
			duty_d = div_side.dk;
		end else if (div_side.neg) begin
			duty_d = div_side.dp - quo;
		end else begin
			duty_d = div_side.dp + quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		duty       <= duty_d;
		drive_mode <= div_side.drive;
		emergency  <= emerg_d;
	end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking bench for fan_curve_duty_select_core: drives temperature samples,
// loads curve settings and checks every duty, drive mode and emergency flag.
// Depends on fcds_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
	import fcds_pkg::*;

	localparam int CURVE_POINTS = 8;
	localparam int PIPE_DEPTH = 9;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_CAP = 40;

	// mode and register codes the package does not name
	localparam logic [1:0] MODE_UNDEF = 2'd3;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [7:0] duty;
		logic       drive;
		logic       emerg;
	} fan_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [7:0]  cpu_temp = 8'd0;
	logic [7:0]  gpu_temp = 8'd0;
	logic        cfg_valid = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [63:0] cfg_data = 64'd0;
	logic        busy;
	logic        done;
	logic [7:0]  duty;
	logic        drive_mode;
	logic        emergency;
	logic        cfg_ready;

	// shadow copy of the configuration registers
	logic [1:0]  cur_mode = MODE_FIRMWARE;
	logic [7:0]  cur_manual = DUTY_FULL;
	logic [1:0]  cur_source = SRC_MAX;
	logic [3:0]  cur_npts = 4'd0;
	logic [63:0] cur_temps = 64'd0;
	logic [63:0] cur_duties = 64'd0;

	fan_out_t pending_duty[$];
	int err_count = 0;
	int samples_taken = 0;
	int results_checked = 0;
	int settings_loaded = 0;
	int emerg_seen = 0;
	int cycle_count = 0;
	bit gaps_on = 1'b0;

	fan_curve_duty_select_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cpu_temp(cpu_temp),
		.gpu_temp(gpu_temp),
		.done(done),
		.duty(duty),
		.drive_mode(drive_mode),
		.emergency(emergency),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_duty.size());
			$display("Verification failed");
			$finish;
		end
	end

	function automatic fan_out_t calc_fan_duty(logic [7:0] c, logic [7:0] g);
		fan_out_t r;
		int t, n, k, tk, tp, dk, dp, span;
		bit hit;
		r = '0;
		hit = 1'b0;
		t = 0;
		if (cur_mode == MODE_MANUAL) begin
			r.duty = cur_manual;
			r.drive = 1'b1;
		end else if (cur_mode == MODE_CURVE) begin
			r.drive = 1'b1;
			if (cur_source != SRC_NONE) begin
				case (cur_source)
					SRC_CPU: t = int'(c);
					SRC_GPU: t = int'(g);
					default: t = int'((c > g) ? c : g);
				endcase
				n = (int'(cur_npts) > CURVE_POINTS) ? CURVE_POINTS : int'(cur_npts);
				// falls through to full duty when past the last point
				r.duty = DUTY_FULL;
				r.emerg = 1'b1;
				for (k = 0; k < n && !hit; k++) begin
					tk = int'(cur_temps[k*8 +: 8]);
					if (t <= tk) begin
						hit = 1'b1;
						r.emerg = 1'b0;
						dk = int'(cur_duties[k*8 +: 8]);
						if (k == 0) begin
							r.duty = 8'(dk);
						end else begin
							tp = int'(cur_temps[(k-1)*8 +: 8]);
							dp = int'(cur_duties[(k-1)*8 +: 8]);
							span = tk - tp;
							if (span <= 0)
								r.duty = 8'(dk);
							else
								r.duty = 8'(dp + ((dk - dp) * (t - tp)) / span);
						end
					end
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int expv, input int gotv);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("ERROR cycle %0d: %s expected %0d got %0d", cycle_count, what, expv, gotv);
	endtask

	// result check first, then capture of the beat accepted at this edge
	always @(posedge clk) begin
		fan_out_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_duty.size() == 0) begin
					report_mismatch("result with nothing pending, duty", -1, int'(duty));
				end else begin
					want = pending_duty.pop_front();
					results_checked++;
					if (emergency)
						emerg_seen++;
					if (duty !== want.duty)
						report_mismatch("duty", int'(want.duty), int'(duty));
					if (drive_mode !== want.drive)
						report_mismatch("drive_mode", int'(want.drive), int'(drive_mode));
					if (emergency !== want.emerg)
						report_mismatch("emergency", int'(want.emerg), int'(emergency));
				end
			end
			if (start && !busy) begin
				pending_duty.push_back(calc_fan_duty(cpu_temp, gpu_temp));
				samples_taken++;
			end
		end
	end

	// valid stays high across back-to-back writes; the next send or settle drops it
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_FAN_MODE:     cur_mode = d[1:0];
			REG_MANUAL_DUTY:  cur_manual = d[7:0];
			REG_CURVE_SOURCE: cur_source = d[1:0];
			REG_POINT_COUNT:  cur_npts = d[3:0];
			REG_CURVE_TEMPS:  cur_temps = d;
			REG_CURVE_DUTIES: cur_duties = d;
			default: ;
		endcase
	endtask

	task automatic send_sample(input logic [7:0] c, input logic [7:0] g);
		cfg_valid <= 1'b0;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16))
				@(posedge clk);
		end
		start <= 1'b1;
		cpu_temp <= c;
		gpu_temp <= g;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// sender holds off until every result is back; safe point for register writes
	task automatic settle_pipe();
		start <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (pending_duty.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 3)
			@(posedge clk);
	endtask

	task automatic test_reset_state();
		// firmware mode out of reset, then curve mode with no points
		send_sample(8'd0, 8'd0);
		send_sample(8'd255, 8'd255);
		settle_pipe();
		write_reg(REG_FAN_MODE, {62'd0, MODE_CURVE});
		send_sample(8'd10, 8'd200);
		settle_pipe();
	endtask

	task automatic test_curve_shape();
		logic [7:0] cpu_list [8];
		int i;
		cpu_list = '{8'd0, 8'd30, 8'd35, 8'd55, 8'd70, 8'd100, 8'd200, 8'd255};
		// ascending with a repeated temperature; two falling segments
		write_reg(REG_CURVE_TEMPS, 64'hC8_50_43_3C_32_32_28_1E);
		write_reg(REG_CURVE_DUTIES, 64'hFF_00_FA_5A_64_3C_28_14);
		write_reg(REG_POINT_COUNT, 64'd8);
		write_reg(REG_CURVE_SOURCE, {62'd0, SRC_CPU});
		for (i = 0; i < 8; i++)
			send_sample(cpu_list[i], 8'($urandom_range(0, 255)));
		settle_pipe();
	endtask

	task automatic test_sources();
		write_reg(REG_CURVE_SOURCE, {62'd0, SRC_GPU});
		send_sample(8'd255, 8'd45);
		settle_pipe();
		write_reg(REG_CURVE_SOURCE, {62'd0, SRC_MAX});
		send_sample(8'd45, 8'd90);
		send_sample(8'd90, 8'd45);
		settle_pipe();
		write_reg(REG_CURVE_SOURCE, {62'd0, SRC_NONE});
		send_sample(8'd255, 8'd255);
		settle_pipe();
	endtask

	task automatic test_point_limits();
		write_reg(REG_CURVE_SOURCE, {62'd0, SRC_CPU});
		write_reg(REG_POINT_COUNT, 64'd15);
		send_sample(8'd210, 8'd0);
		settle_pipe();
		write_reg(REG_POINT_COUNT, 64'd2);
		send_sample(8'd45, 8'd0);
		settle_pipe();
		// out-of-order temperatures: first point at or above t still wins
		write_reg(REG_POINT_COUNT, 64'd8);
		write_reg(REG_CURVE_TEMPS, 64'hFF_F0_E0_D0_C0_3C_0A_1E);
		send_sample(8'd20, 8'd0);
		send_sample(8'd50, 8'd0);
		settle_pipe();
	endtask

	task automatic test_manual_and_fw();
		write_reg(REG_FAN_MODE, {62'd0, MODE_MANUAL});
		write_reg(REG_MANUAL_DUTY, 64'd0);
		send_sample(8'd200, 8'd200);
		settle_pipe();
		write_reg(REG_MANUAL_DUTY, {$urandom, $urandom} | 64'hFF);
		send_sample(8'd0, 8'd0);
		settle_pipe();
		write_reg(REG_FAN_MODE, {62'd0, MODE_UNDEF});
		send_sample(8'd100, 8'd100);
		settle_pipe();
		write_reg(REG_FAN_MODE, {62'd0, MODE_FIRMWARE});
		send_sample(8'd77, 8'd3);
		settle_pipe();
	endtask

	task automatic test_random_curves(input int phases, input int per_phase);
		logic [63:0] temps, duties, d;
		logic [7:0] c, g;
		logic [1:0] mode, src;
		logic [3:0] npts;
		int p, i, k, acc, r;
		for (p = 0; p < phases; p++) begin
			r = $urandom_range(0, 19);
			mode = (r < 3) ? MODE_MANUAL : (r < 17) ? MODE_CURVE :
				(r < 19) ? MODE_FIRMWARE : MODE_UNDEF;
			r = $urandom_range(0, 9);
			src = (r < 3) ? SRC_CPU : (r < 6) ? SRC_GPU : (r < 9) ? SRC_MAX : SRC_NONE;
			r = $urandom_range(0, 15);
			npts = (r == 0) ? 4'd0 : (r == 1) ? 4'($urandom_range(9, 15)) :
				(r < 6) ? 4'($urandom_range(1, 7)) : 4'd8;
			if ($urandom_range(0, 5) == 0) begin
				temps = {$urandom, $urandom};
			end else begin
				acc = $urandom_range(0, 60);
				for (k = 0; k < CURVE_POINTS; k++) begin
					if (acc > 255)
						acc = 255;
					temps[k*8 +: 8] = 8'(acc);
					acc += ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 40));
				end
			end
			duties = {$urandom, $urandom};
			// corner settings first: all points at the top, then all at zero
			if (p < 2) begin
				mode = MODE_CURVE;
				src = SRC_MAX;
				npts = 4'd8;
				temps = (p == 0) ? '1 : '0;
				duties = (p == 0) ? '0 : '1;
			end
			d = {$urandom, $urandom};
			write_reg(REG_FAN_MODE, {d[63:2], mode});
			d = {$urandom, $urandom};
			write_reg(REG_CURVE_SOURCE, {d[63:2], src});
			d = {$urandom, $urandom};
			write_reg(REG_POINT_COUNT, {d[63:4], npts});
			write_reg(REG_CURVE_TEMPS, temps);
			write_reg(REG_CURVE_DUTIES, duties);
			write_reg(REG_MANUAL_DUTY, {$urandom, $urandom});
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
					{$urandom, $urandom});
			settings_loaded++;
			for (i = 0; i < per_phase; i++) begin
				c = 8'($urandom_range(0, 255));
				g = 8'($urandom_range(0, 255));
				// land on or next to a curve point now and then
				if ($urandom_range(0, 3) == 0) begin
					k = $urandom_range(0, CURVE_POINTS - 1);
					acc = int'(cur_temps[k*8 +: 8]) + int'($urandom_range(0, 2)) - 1;
					if (acc < 0)
						acc = 0;
					if (acc > 255)
						acc = 255;
					if ($urandom_range(0, 1))
						c = 8'(acc);
					else
						g = 8'(acc);
				end
				send_sample(c, g);
			end
			settle_pipe();
		end
	endtask

	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gaps_on = 1'b1;
		test_reset_state();
		test_curve_shape();
		test_sources();
		test_point_limits();
		test_manual_and_fw();
		test_random_curves(14, 60);
		// closing stretch at full rate, no sender gaps
		gaps_on = 1'b0;
		test_random_curves(2, 50);

		$display("%0d samples over %0d random settings plus directed corners;", samples_taken,
			settings_loaded);
		$display("%0d results checked, %0d with the emergency flag, %0d mismatches.",
			results_checked, emerg_seen, err_count);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
